// ===== hdl/pmmu_pkg.sv =====
package pmmu_pkg;

    // Default geometry
    localparam int SEGMENTS_DEF = 16;
    localparam int MODULES_DEF  = 16;
    localparam int FRAMES_DEF   = 16;
    localparam int PAGES        = 16;

    // Function codes (s_axis_tuser)
    localparam logic [1:0] FN_TRANSLATE  = 2'd0;
    localparam logic [1:0] FN_MAP        = 2'd1;
    localparam logic [1:0] FN_LONG_RESET = 2'd2;

    // Result status codes (m_axis_tuser)
    localparam logic [2:0] ST_PROM     = 3'd0;
    localparam logic [2:0] ST_FAIL     = 3'd1;
    localparam logic [2:0] ST_MAPPED   = 3'd2;
    localparam logic [2:0] ST_UNMAPPED = 3'd3;
    localparam logic [2:0] ST_ACK      = 3'd4;

    localparam logic [3:0] PROM_SEGMENT = 4'd0;
    localparam logic [3:0] PROM_PAGE    = 4'd15;

    localparam logic [4:0] PRESENT_RESET = 5'd16;

    typedef struct packed {
        logic       valid;
        logic [3:0] phys_module;
        logic [3:0] phys_frame;
    } t_entry;

endpackage

// ===== hdl/paged_memory_map_unit_core.sv =====
// Channel      Direction  Signals                          Payload
// s_axis       in         tvalid tready tdata[23:0] tuser  request item, tuser = func
// m_axis       out        tvalid tready tdata[15:0] tuser  result item, tuser = status
// apb          in         psel penable pwrite paddr pwdata present_modules at addresses 0-3
//
// An item is accepted into a read stage that fetches its map entry from the RAM; from there
// it is resolved into the output register, from which its result leaves.
// One item per cycle is sustained while the output is not stalled; a translate right after
// a map of the same entry takes the entry from a bypass register, since the RAM read then
// still sees the old word. After reset a clearing pass writes every entry invalid, one per
// cycle with s_axis_tready low; reset also clears both flags.
// A stalled output holds the resolve stage, which in turn holds s_axis_tready low.
module paged_memory_map_unit_core #(
    parameter int SEGMENTS = pmmu_pkg::SEGMENTS_DEF,
    parameter int MODULES  = pmmu_pkg::MODULES_DEF,
    parameter int FRAMES   = pmmu_pkg::FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] segment, [7:4] page, [11:8] phys_module, [15:12] phys_frame,
    // [16] dealloc, [17] show_prom, [18] hide_prom, [19] set_done, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    // [1:0] func
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] out_module, [7:4] out_frame, [8] write_enable, [9] module_missing, [15:10] zero
    output logic [15:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pmmu_pkg::*;

    localparam int DEPTH = SEGMENTS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [4:0] SEG_LIM = 5'(SEGMENTS);
    localparam logic [4:0] MOD_LIM = 5'(MODULES);
    localparam logic [4:0] FRM_LIM = 5'(FRAMES);

    // Configuration
    logic [4:0] r_present;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= PRESENT_RESET;
        end else if (cfg_wr) begin
            r_present <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {27'd0, r_present} : 32'd0;

    // Input fields
    logic [3:0] in_seg;
    logic [3:0] in_page;
    logic [AW-1:0] in_addr;
    logic       in_fire;

    assign in_seg  = s_axis_tdata[3:0];
    assign in_page = s_axis_tdata[7:4];
    assign in_addr = AW'({in_seg, in_page});

    // Resolve stage
    logic          r_s1_valid;
    logic [1:0]    r_s1_func;
    logic [3:0]    r_s1_seg;
    logic [3:0]    r_s1_page;
    logic [3:0]    r_s1_mod;
    logic [3:0]    r_s1_frm;
    logic          r_s1_dealloc;
    logic          r_s1_show;
    logic          r_s1_hide;
    logic          r_s1_done;
    logic [AW-1:0] s1_addr;
    logic          s1_seg_ok;
    logic          s1_go;
    logic          s1_fire;

    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [3:0]    r_out_mod;
    logic [3:0]    r_out_frm;
    logic          r_out_we;
    logic          r_out_miss;

    logic          r_prom_hidden;
    logic          r_map_ready;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          wr_en;
    t_entry        wr_data;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    t_entry        rd_data;
    t_entry        entry;
    logic          r_fwd_hit;
    t_entry        r_fwd_data;

    assign s1_go         = !r_out_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && s1_go;
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || s1_go);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign s1_addr   = AW'({r_s1_seg, r_s1_page});
    assign s1_seg_ok = {1'b0, r_s1_seg} < SEG_LIM;
    assign wr_en     = s1_fire && (r_s1_func == FN_MAP) && s1_seg_ok;
    assign wr_data   = '{valid: !r_s1_dealloc, phys_module: r_s1_mod, phys_frame: r_s1_frm};

    // Walk every entry to invalid after reset, one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign ram_we    = r_clr_busy || wr_en;
    assign ram_waddr = r_clr_busy ? r_clr_addr : s1_addr;
    assign ram_wdata = r_clr_busy ? '0 : wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_func    <= s_axis_tuser;
            r_s1_seg     <= in_seg;
            r_s1_page    <= in_page;
            r_s1_mod     <= s_axis_tdata[11:8];
            r_s1_frm     <= s_axis_tdata[15:12];
            r_s1_dealloc <= s_axis_tdata[16];
            r_s1_show    <= s_axis_tdata[17];
            r_s1_hide    <= s_axis_tdata[18];
            r_s1_done    <= s_axis_tdata[19];
            // bypass: the RAM returns the old word when the write lands this edge
            r_fwd_hit    <= wr_en && (s1_addr == in_addr);
            r_fwd_data   <= wr_data;
        end
    end

    pmmu_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_fire),
        .i_raddr (in_addr),
        .o_rdata (rd_data)
    );

    assign entry = r_fwd_hit ? r_fwd_data : rd_data;

    // Flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prom_hidden <= 1'b0;
            r_map_ready   <= 1'b0;
        end else if (s1_fire) begin
            unique case (r_s1_func)
                FN_MAP: begin
                    r_prom_hidden <= (!r_prom_hidden && r_s1_hide) ||
                                     (r_prom_hidden && !r_s1_show);
                    if (r_s1_done) begin
                        r_map_ready <= 1'b1;
                    end
                end
                FN_LONG_RESET: begin
                    r_prom_hidden <= 1'b0;
                    r_map_ready   <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Translate
    logic [4:0] present;
    logic [4:0] first_mod;
    logic       missing;
    logic [2:0] n_status;
    logic [3:0] n_mod;
    logic [3:0] n_frm;
    logic       n_we;
    logic       n_miss;

    assign present   = (r_present > MOD_LIM) ? MOD_LIM : r_present;
    assign first_mod = MOD_LIM - present;
    assign missing   = ({1'b0, entry.phys_module} < first_mod) ||
                       ({1'b0, entry.phys_module} >= MOD_LIM) ||
                       ({1'b0, entry.phys_frame} >= FRM_LIM);

    always_comb begin
        n_status = ST_ACK;
        n_mod    = 4'd0;
        n_frm    = 4'd0;
        n_we     = 1'b0;
        n_miss   = 1'b0;
        if (r_s1_func == FN_TRANSLATE) begin
            priority if (r_s1_seg == PROM_SEGMENT && r_s1_page == PROM_PAGE &&
                         !r_prom_hidden) begin
                n_status = ST_PROM;
            end else if (!r_map_ready) begin
                n_status = ST_FAIL;
            end else if (!s1_seg_ok || !entry.valid) begin
                n_status = ST_UNMAPPED;
            end else begin
                n_status = ST_MAPPED;
                n_mod    = entry.phys_module;
                n_frm    = entry.phys_frame;
                n_we     = !missing;
                n_miss   = missing;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_status <= n_status;
            r_out_mod    <= n_mod;
            r_out_frm    <= n_frm;
            r_out_we     <= n_we;
            r_out_miss   <= n_miss;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {6'd0, r_out_miss, r_out_we, r_out_frm, r_out_mod};

    // Checks
    a_long_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_func == FN_LONG_RESET |=> !r_map_ready && !r_prom_hidden)
        else $error("long reset left a flag set");

    a_set_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_func == FN_MAP && r_s1_done |=> r_map_ready)
        else $error("set_done did not mark allocation done");

    a_mapped_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_MAPPED |-> r_out_we != r_out_miss)
        else $error("mapped result with inconsistent write_enable/module_missing");

    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_MAPPED |->
            !r_out_we && !r_out_miss && r_out_mod == 4'd0 && r_out_frm == 4'd0)
        else $error("non-mapped result carries data");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while both stages are held");

endmodule

// ===== hdl/pmmu_ram.sv =====
module pmmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/pmmu_score_pkg.sv =====
package pmmu_score_pkg;
    import pmmu_pkg::*;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] out_module;
        logic [3:0] out_frame;
        logic       write_enable;
        logic       module_missing;
    } t_map_result;

    class t_map_scoreboard;
        t_entry      page_map [256];
        bit          entry_valid [256];
        bit          prom_hidden;
        bit          map_ready;
        logic [4:0]  present_modules;
        t_map_result pending_results [$];
        int          errors;
        int          status_count [5];

        function new();
            foreach (entry_valid[i]) begin
                entry_valid[i] = 1'b0;
                page_map[i]    = '0;
            end
            foreach (status_count[i]) status_count[i] = 0;
            prom_hidden     = 1'b0;
            map_ready       = 1'b0;
            present_modules = PRESENT_RESET;
            errors          = 0;
        endfunction

        function void set_present(logic [4:0] value);
            present_modules = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Work out the answer for one accepted request and advance the map state.
        function void predict_request(logic [1:0] func, logic [23:0] data);
            logic [3:0]  seg;
            logic [3:0]  page;
            logic [3:0]  mod_no;
            logic [3:0]  frame;
            logic        dealloc;
            logic        show;
            logic        hide;
            logic        done;
            logic [7:0]  idx;
            int          present;
            int          first_present;
            t_map_result r;
            {done, hide, show, dealloc, frame, mod_no, page, seg} = data[19:0];
            idx = {seg, page};
            r = '0;
            r.status = ST_ACK;
            case (func)
                FN_TRANSLATE: begin
                    if (seg == PROM_SEGMENT && page == PROM_PAGE && !prom_hidden) begin
                        r.status = ST_PROM;
                    end else if (!map_ready) begin
                        r.status = ST_FAIL;
                    end else if (!entry_valid[idx]) begin
                        r.status = ST_UNMAPPED;
                    end else begin
                        // clamp the register to the module count
                        present = (present_modules > MODULES_DEF) ? MODULES_DEF
                                                                  : int'(present_modules);
                        first_present    = MODULES_DEF - present;
                        r.status         = ST_MAPPED;
                        r.out_module     = page_map[idx].phys_module;
                        r.out_frame      = page_map[idx].phys_frame;
                        r.module_missing = int'(page_map[idx].phys_module) < first_present ||
                                           int'(page_map[idx].phys_module) >= MODULES_DEF ||
                                           int'(page_map[idx].phys_frame) >= FRAMES_DEF;
                        r.write_enable   = !r.module_missing;
                    end
                end
                FN_MAP: begin
                    prom_hidden = (!prom_hidden && hide) || (prom_hidden && !show);
                    entry_valid[idx]          = !dealloc;
                    page_map[idx].phys_module = mod_no;
                    page_map[idx].phys_frame  = frame;
                    if (done) map_ready = 1'b1;
                end
                FN_LONG_RESET: begin
                    prom_hidden = 1'b0;
                    map_ready   = 1'b0;
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(logic [2:0] status, logic [15:0] data);
            t_map_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual status %0d data %h",
                         $time, status, data);
                return;
            end
            want = pending_results.pop_front();
            status_count[want.status]++;
            compare_field("status", want.status, status);
            compare_field("out_module", want.out_module, data[3:0]);
            compare_field("out_frame", want.out_frame, data[7:4]);
            compare_field("write_enable", want.write_enable, data[8]);
            compare_field("module_missing", want.module_missing, data[9]);
            compare_field("tdata pad", 0, data[15:10]);
        endfunction
    endclass

endpackage

// ===== tb/paged_memory_map_unit_core_test.sv =====
module paged_memory_map_unit_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pmmu_pkg::*;
    import pmmu_score_pkg::*;

    localparam logic [1:0] FN_UNUSED            = 2'd3;
    localparam logic [2:0] ADDR_PRESENT_MODULES = 3'd0;
    localparam logic [2:0] ADDR_HOLE            = 3'd4;
    localparam int         RANDOM_PER_PHASE     = 170;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_map_scoreboard map_shadow = new();

    int rx_hold_cycles = 0;
    int burst_left     = 0;
    bit tx_busy        = 1'b1;
    bit rx_busy        = 1'b1;

    paged_memory_map_unit_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Check results before noting requests: a request never answers in its own cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                map_shadow.check_result(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                map_shadow.predict_request(s_axis_tuser, s_axis_tdata);
            if (psel && penable && pwrite && pready && paddr == ADDR_PRESENT_MODULES)
                map_shadow.set_present(pwdata[4:0]);
        end
    end

    task automatic send_item(input logic [1:0] func, input logic [23:0] data);
        int gap;
        gap = (tx_busy && burst_left == 0) ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic send_fields(input logic [1:0] func, input logic [3:0] seg,
                               input logic [3:0] page, input logic [3:0] mod_no,
                               input logic [3:0] frame, input logic dealloc,
                               input logic show, input logic hide, input logic done);
        send_item(func, {4'b0, done, hide, show, dealloc, frame, mod_no, page, seg});
    endtask

    // Mostly a small working set so translates land on mapped entries.
    task automatic send_random();
        int         pick;
        logic [1:0] func;
        logic [3:0] seg;
        logic [3:0] page;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            func = FN_TRANSLATE;
        else if (pick < 92)
            func = FN_MAP;
        else if (pick < 96)
            func = FN_LONG_RESET;
        else
            func = FN_UNUSED;
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 3))
                0: seg = PROM_SEGMENT;
                1: seg = 4'd1;
                2: seg = 4'd2;
                default: seg = 4'd15;
            endcase
            page = ($urandom_range(0, 4) == 0) ? PROM_PAGE : 4'($urandom_range(0, 3));
        end else begin
            seg  = 4'($urandom_range(0, 15));
            page = 4'($urandom_range(0, 15));
        end
        send_fields(func, seg, page, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    $urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0,
                    $urandom_range(0, 3) == 0, $urandom_range(0, 1) == 1);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [4:0] value);
        logic [31:0] word;
        word      = $urandom();
        word[4:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid and hold until every answer is back, plus the pipeline depth.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (map_shadow.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            stall = rx_busy ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        logic [4:0] settings [6];
        int         p;
        int         i;
        settings[0] = 5'd16;
        settings[1] = 5'd0;
        settings[2] = 5'd31;
        settings[3] = 5'd1;
        settings[4] = 5'd8;
        settings[5] = 5'($urandom_range(0, 31));
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FN_TRANSLATE;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fresh state: PROM shown, allocation not done
        send_fields(FN_TRANSLATE, PROM_SEGMENT, PROM_PAGE, 4'd0, 4'd0, 0, 0, 0, 0);
        send_fields(FN_TRANSLATE, 4'd3, 4'd4, 4'd0, 4'd0, 0, 0, 0, 0);
        send_fields(FN_MAP, 4'd0, 4'd0, 4'd15, 4'd15, 0, 0, 0, 0);
        send_fields(FN_TRANSLATE, 4'd0, 4'd0, 4'd0, 4'd0, 0, 0, 0, 0);
        send_fields(FN_MAP, 4'd15, 4'd15, 4'd0, 4'd0, 0, 0, 0, 1);
        send_fields(FN_TRANSLATE, 4'd15, 4'd15, 4'd0, 4'd0, 0, 0, 0, 0);
        send_fields(FN_TRANSLATE, 4'd0, 4'd0, 4'd0, 4'd0, 0, 0, 0, 0);
        send_fields(FN_TRANSLATE, 4'd7, 4'd7, 4'd0, 4'd0, 0, 0, 0, 0);
        // hide the PROM and map its page
        send_fields(FN_MAP, PROM_SEGMENT, PROM_PAGE, 4'd5, 4'd9, 0, 0, 1, 0);
        send_fields(FN_TRANSLATE, PROM_SEGMENT, PROM_PAGE, 4'd0, 4'd0, 0, 0, 0, 0);
        // show and hide together toggle the flag
        send_fields(FN_MAP, PROM_SEGMENT, PROM_PAGE, 4'd0, 4'd0, 1, 1, 1, 0);
        send_fields(FN_TRANSLATE, PROM_SEGMENT, PROM_PAGE, 4'd0, 4'd0, 0, 0, 0, 0);
        send_fields(FN_MAP, 4'd15, 4'd15, 4'd0, 4'd0, 1, 1, 1, 0);
        send_fields(FN_TRANSLATE, PROM_SEGMENT, PROM_PAGE, 4'd0, 4'd0, 0, 0, 0, 0);
        send_fields(FN_TRANSLATE, 4'd15, 4'd15, 4'd0, 4'd0, 0, 0, 0, 0);
        // map then translate the same entry, back to back when no random gap falls between
        send_fields(FN_MAP, 4'd15, 4'd15, 4'd9, 4'd3, 0, 1, 0, 0);
        send_fields(FN_TRANSLATE, 4'd15, 4'd15, 4'd0, 4'd0, 0, 0, 0, 0);
        send_fields(FN_UNUSED, 4'd15, 4'd15, 4'd15, 4'd15, 1, 1, 1, 1);
        send_fields(FN_TRANSLATE, PROM_SEGMENT, PROM_PAGE, 4'd0, 4'd0, 0, 0, 0, 0);
        // long reset keeps the table
        send_fields(FN_LONG_RESET, 4'd0, 4'd0, 4'd0, 4'd0, 0, 0, 0, 0);
        send_fields(FN_TRANSLATE, 4'd0, 4'd0, 4'd0, 4'd0, 0, 0, 0, 0);
        send_fields(FN_TRANSLATE, PROM_SEGMENT, PROM_PAGE, 4'd0, 4'd0, 0, 0, 0, 0);
        send_fields(FN_MAP, 4'd1, 4'd2, 4'd7, 4'd7, 1, 0, 1, 1);
        send_fields(FN_TRANSLATE, 4'd0, 4'd0, 4'd0, 4'd0, 0, 0, 0, 0);
        send_fields(FN_TRANSLATE, 4'd1, 4'd2, 4'd0, 4'd0, 0, 0, 0, 0);
        quiesce();

        for (p = 0; p < 6; p++) begin
            // a write to an unused address must leave the register alone
            if (p == 3) write_register(ADDR_HOLE, 5'd0);
            write_register(ADDR_PRESENT_MODULES, settings[p]);
            for (i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (i % 40 == 0) begin
                    tx_busy = $urandom_range(0, 2) != 0;
                    rx_busy = $urandom_range(0, 2) != 0;
                end
                if (i == 60) begin
                    rx_hold_cycles = 48;
                    burst_left     = 30;
                end
                if (i == 120) quiesce();
                send_random();
            end
            quiesce();
        end

        $display("Covered %0d PROM, %0d not-configured, %0d mapped, %0d unmapped translates",
                 map_shadow.status_count[ST_PROM], map_shadow.status_count[ST_FAIL],
                 map_shadow.status_count[ST_MAPPED], map_shadow.status_count[ST_UNMAPPED]);
        $display("and %0d acknowledged commands over six present-module settings",
                 map_shadow.status_count[ST_ACK]);
        if (map_shadow.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, map_shadow.pending());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
